>>> hdl/wwr_pkg.sv
// ----------------------------------------------------------------------------
// wwr_pkg
// Shared types, register indexes and constants of the whole-word replacer.
// ----------------------------------------------------------------------------
package wwr_pkg;

  // Default depth of the word buffer, in bytes.
  localparam int WORD_MAX_DEF = 16;

  // Width of a burst byte count. It holds 0 to 31, which covers both the
  // longest buffered word and the longest replacement word.
  localparam int SEQ_W = 5;

  // Longest replacement word, in bytes.
  localparam logic [4:0] REP_MAX = 5'd16;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] NUL_CHAR   = 8'h00;

  // Configuration register indexes.
  localparam logic [2:0] REG_PATTERN_LOW        = 3'd0;
  localparam logic [2:0] REG_PATTERN_HIGH       = 3'd1;
  localparam logic [2:0] REG_PATTERN_LENGTH     = 3'd2;
  localparam logic [2:0] REG_REPLACEMENT_LOW    = 3'd3;
  localparam logic [2:0] REG_REPLACEMENT_HIGH   = 3'd4;
  localparam logic [2:0] REG_REPLACEMENT_LENGTH = 3'd5;

  typedef struct packed {
    logic [7:0] char_in;
    logic       text_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       last;
  } out_item_t;

  // Work that one accepted byte hands to the burst unit, in output order:
  // an optional separator space, a run of word bytes (from the cell chain or
  // from the replacement word), an optional trailing byte, or a bare marker.
  typedef struct packed {
    logic             space;
    logic [SEQ_W-1:0] count;
    logic             rep;
    logic             tail;
    logic [7:0]       tail_byte;
    logic             bare;
    logic             last;
  } plan_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == SPACE_CHAR) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

endpackage

>>> hdl/wwr_cell.sv
// ----------------------------------------------------------------------------
// wwr_cell
// One byte of the word buffer with its pattern comparator and shift link.
// ----------------------------------------------------------------------------
module wwr_cell (
  input  logic       clk,
  input  logic       wr_sel,
  input  logic       wr_go,
  input  logic [7:0] wr_byte,
  input  logic       shift_en,
  input  logic [7:0] shift_in,
  input  logic [7:0] pat_byte,
  output logic [7:0] data,
  output logic       eq
);

  logic [7:0] eff;

  // The compare sees a byte that is being written in this cycle, so a word
  // that ends on the byte that completes it is judged correctly.
  assign eff = wr_sel ? wr_byte : data;
  assign eq  = (eff == pat_byte);

  // A write wins over a shift: a new word may start in the cycle that moves
  // the last byte of the previous one out.
  always_ff @(posedge clk) begin
    if (wr_sel && wr_go) begin
      data <= wr_byte;
    end else if (shift_en) begin
      data <= shift_in;
    end
  end

endmodule

>>> hdl/wwr_burst.sv
// ----------------------------------------------------------------------------
// wwr_burst
// Plays out the result bytes of one transaction and holds the output register.
// ----------------------------------------------------------------------------
module wwr_burst (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  wwr_pkg::plan_t      plan,
  output logic                take,
  input  logic [7:0]          head_byte,
  output logic                shift_en,
  input  logic [127:0]        rep_bytes,
  output logic                out_valid,
  input  logic                out_stall,
  output wwr_pkg::out_item_t  out_data
);
  import wwr_pkg::*;

  logic             space;
  logic [SEQ_W-1:0] count;
  logic [3:0]       idx;
  logic             rep;
  logic             tail;
  logic [7:0]       tail_byte;
  logic             bare;
  logic             end_flag;

  logic      busy;
  logic      final_item;
  logic      advance;
  out_item_t item;

  assign busy = space || (count != '0) || tail || bare;

  always_comb begin
    if (space) begin
      final_item = (count == '0) && !tail && !bare;
    end else if (count != '0) begin
      final_item = (count == SEQ_W'(1)) && !tail && !bare;
    end else begin
      final_item = 1'b1;
    end
  end

  assign advance  = busy && (!out_valid || !out_stall);
  assign take     = !busy || (advance && final_item);
  assign shift_en = advance && !space && (count != '0) && !rep;

  always_comb begin
    item.char_valid = 1'b1;
    item.last       = end_flag && final_item;
    if (space) begin
      item.char_out = SPACE_CHAR;
    end else if (count != '0) begin
      item.char_out = rep ? rep_bytes[{idx, 3'b000} +: 8] : head_byte;
    end else if (tail) begin
      item.char_out = tail_byte;
    end else begin
      item.char_out   = NUL_CHAR;
      item.char_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      space <= 1'b0;
      count <= '0;
      tail  <= 1'b0;
      bare  <= 1'b0;
    end else if (load) begin
      space <= plan.space;
      count <= plan.count;
      tail  <= plan.tail;
      bare  <= plan.bare;
    end else if (advance) begin
      if (space) begin
        space <= 1'b0;
      end else if (count != '0) begin
        count <= count - SEQ_W'(1);
      end else if (tail) begin
        tail <= 1'b0;
      end else begin
        bare <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx       <= '0;
      rep       <= plan.rep;
      tail_byte <= plan.tail_byte;
      end_flag  <= plan.last;
    end else if (advance && !space && (count != '0)) begin
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= item;
    end
  end

endmodule

>>> hdl/whole_word_replacer_unit.sv
// ----------------------------------------------------------------------------
// whole_word_replacer_unit
// Streaming whole-word find and replace over a byte stream.
// ----------------------------------------------------------------------------
// The first result of a transaction passes the burst unit registers and then
// the output register. One byte per cycle goes in while the results come one
// per byte and the output does not stall; a word-end burst holds the input
// until its last byte, as the burst unit plays out one byte per cycle unstalled.
// Reset (synchronous, active high) clears word state, the burst unit and the
// configuration registers; the word buffer bytes are not cleared.
module whole_word_replacer_unit #(
  parameter int WORD_MAX = wwr_pkg::WORD_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                text_valid,
  output logic                text_stall,
  input  wwr_pkg::in_item_t   text_item,
  output logic                result_valid,
  input  logic                result_stall,
  output wwr_pkg::out_item_t  result_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import wwr_pkg::*;

  // Width of the word byte count, able to hold WORD_MAX itself.
  localparam int CW = $clog2(WORD_MAX + 1);

  // Configuration registers. The user writes only when idle; not enforced.
  logic [63:0] pattern_low;
  logic [63:0] pattern_high;
  logic [4:0]  pattern_length;
  logic [63:0] replacement_low;
  logic [63:0] replacement_high;
  logic [4:0]  replacement_length;

  // Word state: bytes buffered so far, whether an overlong word is
  // streaming straight through, and whether a word has gone out already.
  logic [CW-1:0] word_count;
  logic          passing_through;
  logic          word_seen;

  logic [CW-1:0] word_count_next;
  logic          passing_through_next;
  logic          word_seen_next;

  logic          take;
  logic          accept;
  logic          shift_en;
  logic          cur_space;
  logic          store_wr;
  logic          eq_all;
  logic [CW-1:0] pat_len;
  logic [4:0]    rep_len;
  logic [127:0]  pat_vec;
  logic [127:0]  rep_vec;
  plan_t         plan;

  logic [WORD_MAX-1:0] wr_sel;
  logic [WORD_MAX-1:0] cell_eq;
  logic [7:0]          cell_data [WORD_MAX];

  assign cfg_ready  = 1'b1;
  assign text_stall = !take;
  assign accept     = text_valid && take;

  assign pat_vec = {pattern_high, pattern_low};
  assign rep_vec = {replacement_high, replacement_low};

  // Lengths beyond the buffer depth or the replacement capacity saturate.
  assign pat_len = (pattern_length > 5'(WORD_MAX)) ? CW'(WORD_MAX)
                                                    : pattern_length[CW-1:0];
  assign rep_len = (replacement_length > REP_MAX) ? REP_MAX : replacement_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low        <= '0;
      pattern_high       <= '0;
      pattern_length     <= '0;
      replacement_low    <= '0;
      replacement_high   <= '0;
      replacement_length <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_LOW:        pattern_low        <= cfg_data;
        REG_PATTERN_HIGH:       pattern_high       <= cfg_data;
        REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[4:0];
        REG_REPLACEMENT_LOW:    replacement_low    <= cfg_data;
        REG_REPLACEMENT_HIGH:   replacement_high   <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  assign cur_space = is_space(text_item.char_in);

  // A non-space byte is buffered while the word is still no longer than the
  // pattern. It lands in the cell that the current count points at.
  assign store_wr = !cur_space && !passing_through && (word_count < pat_len);

  // The cell chain. Each cell holds one byte of the current word and compares
  // it with its own pattern byte; during a word-end burst the chain shifts
  // toward cell 0, which feeds the burst unit.
  for (genvar i = 0; i < WORD_MAX; i++) begin : g_cell
    logic [7:0] link;

    assign wr_sel[i] = store_wr && (word_count == CW'(i));

    if (i == WORD_MAX - 1) begin : g_end
      assign link = NUL_CHAR;
    end else begin : g_mid
      assign link = cell_data[i+1];
    end

    wwr_cell u_cell (
      .clk      (clk),
      .wr_sel   (wr_sel[i]),
      .wr_go    (accept),
      .wr_byte  (text_item.char_in),
      .shift_en (shift_en),
      .shift_in (link),
      .pat_byte (pat_vec[8*i +: 8]),
      .data     (cell_data[i]),
      .eq       (cell_eq[i])
    );
  end

  // All cells within the pattern length agree with the pattern. A word can
  // only match when its length equals the pattern length, so masking by the
  // pattern length is enough.
  always_comb begin
    eq_all = 1'b1;
    for (int i = 0; i < WORD_MAX; i++) begin
      if ((CW'(i) < pat_len) && !cell_eq[i]) begin
        eq_all = 1'b0;
      end
    end
  end

  // Work out the results of the offered byte and the word state after it.
  always_comb begin
    plan                 = '0;
    plan.tail_byte       = text_item.char_in;
    word_count_next      = word_count;
    passing_through_next = passing_through;
    word_seen_next       = word_seen;

    if (!cur_space) begin
      if (passing_through) begin
        plan.tail = 1'b1;
      end else if (store_wr) begin
        word_count_next = word_count + CW'(1);
      end else begin
        // The word has outgrown the pattern: flush what is buffered and
        // let the rest of the word stream through.
        plan.space           = word_seen;
        plan.count           = SEQ_W'(word_count);
        plan.tail            = 1'b1;
        word_count_next      = '0;
        passing_through_next = 1'b1;
        word_seen_next       = 1'b1;
      end
    end

    if (cur_space || text_item.text_end) begin
      if (passing_through_next) begin
        passing_through_next = 1'b0;
      end else if (word_count_next != '0) begin
        plan.space = word_seen_next;
        if ((word_count_next == pat_len) && eq_all) begin
          plan.rep   = 1'b1;
          plan.count = rep_len;
        end else begin
          plan.count = SEQ_W'(word_count_next);
        end
        word_seen_next  = 1'b1;
        word_count_next = '0;
      end
    end

    if (text_item.text_end) begin
      plan.last            = 1'b1;
      plan.bare            = !plan.space && (plan.count == '0) && !plan.tail;
      word_count_next      = '0;
      passing_through_next = 1'b0;
      word_seen_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count      <= '0;
      passing_through <= 1'b0;
      word_seen       <= 1'b0;
    end else if (accept) begin
      word_count      <= word_count_next;
      passing_through <= passing_through_next;
      word_seen       <= word_seen_next;
    end
  end

  // The burst unit takes a new transaction when it is free or is sending the
  // last byte of the current one, so bytes flow one per cycle while unstalled.
  wwr_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .plan      (plan),
    .take      (take),
    .head_byte (cell_data[0]),
    .shift_en  (shift_en),
    .rep_bytes (rep_vec),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_data  (result_item)
  );

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for whole_word_replacer_unit. Texts are queued as byte
// transactions and fed to the block by a clocked driver. Each accepted byte is
// run through a bit-exact predictor of the word rewriter. A clocked monitor
// compares every result transaction, field by field, against the oldest
// predicted byte. Configuration changes happen only while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wwr_pkg::*;

  // Length of the one long receiver hold-off, in cycles.
  localparam int HOLD_CYCLES = 300;
  // Cycles without any accepted transaction before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 3000;
  // Quiet cycles allowed after the last expected byte before touching registers.
  localparam int SETTLE_CYCLES = 20;
  // An index with no register behind it; a write there must change nothing.
  localparam logic [2:0] REG_SPARE = 3'd7;

  typedef struct {
    in_item_t item;
    bit       drain_first;
  } queued_byte_t;

  // Block ports. Every input starts at a known value.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_stall;
  in_item_t    text_item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  out_item_t   result_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // Bench bookkeeping.
  queued_byte_t source_bytes [$];
  out_item_t    expected_chars [$];
  out_item_t    step_out [$];
  int unsigned  bytes_queued = 0;
  int unsigned  bytes_taken = 0;
  int unsigned  error_count = 0;
  int unsigned  stuck_cycles = 0;
  int unsigned  hold_left = 0;
  bit           hold_request = 1'b0;
  bit           hold_done = 1'b0;
  bit           quiet = 1'b0;
  bit           drain_next = 1'b0;

  // Shadow copy of the configuration registers, at their reset values.
  logic [63:0] pat_lo_q = '0;
  logic [63:0] pat_hi_q = '0;
  logic [4:0]  pat_len_q = '0;
  logic [63:0] rep_lo_q = '0;
  logic [63:0] rep_hi_q = '0;
  logic [4:0]  rep_len_q = 5'd1;

  // Word state of the predictor.
  logic [7:0]  word_buf [16];
  int unsigned buf_count = 0;
  bit          streaming = 1'b0;
  bit          word_emitted = 1'b0;

  whole_word_replacer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_item    (text_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Tab, line feed, vertical tab, form feed, carriage return and space.
  function automatic bit blank(input logic [7:0] c);
    return (c == SPACE_CHAR) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [7:0] byte_at(input logic [127:0] word, input int unsigned i);
    return word[i*8 +: 8];
  endfunction

  // Both length registers hold 0 to 31, but neither word is longer than 16.
  function automatic int unsigned clamp16(input logic [4:0] n);
    return (n > 5'd16) ? 16 : int'(n);
  endfunction

  function automatic void emit_char(input logic [7:0] c);
    step_out.push_back(out_item_t'{char_out: c, char_valid: 1'b1, last: 1'b0});
  endfunction

  // Works out the bytes that one accepted source byte releases and appends
  // them to the expected stream.
  function automatic void rewrite_byte(input in_item_t it);
    int unsigned plen;
    bit          hit;
    out_item_t   tail;
    step_out.delete();
    plen = clamp16(pat_len_q);
    if (!blank(it.char_in)) begin
      if (streaming) begin
        emit_char(it.char_in);
      end else if (buf_count < plen) begin
        word_buf[buf_count] = it.char_in;
        buf_count++;
      end else begin
        // The word is longer than the pattern and can no longer match: flush
        // what was held back and let the rest of the word stream through.
        if (word_emitted) emit_char(SPACE_CHAR);
        for (int i = 0; i < buf_count; i++) emit_char(word_buf[i]);
        emit_char(it.char_in);
        buf_count = 0;
        streaming = 1'b1;
        word_emitted = 1'b1;
      end
    end
    // Whitespace ends the word; so does the last byte of a text, after it
    // has joined the word.
    if (blank(it.char_in) || it.text_end) begin
      if (streaming) begin
        streaming = 1'b0;
      end else if (buf_count != 0) begin
        hit = (buf_count == plen);
        for (int i = 0; i < buf_count; i++)
          if (word_buf[i] != byte_at({pat_hi_q, pat_lo_q}, i)) hit = 1'b0;
        if (word_emitted) emit_char(SPACE_CHAR);
        if (hit) begin
          for (int i = 0; i < clamp16(rep_len_q); i++)
            emit_char(byte_at({rep_hi_q, rep_lo_q}, i));
        end else begin
          for (int i = 0; i < buf_count; i++) emit_char(word_buf[i]);
        end
        word_emitted = 1'b1;
        buf_count = 0;
      end
    end
    if (it.text_end) begin
      // A text end with nothing to say still produces a bare marker.
      if (step_out.size() == 0)
        step_out.push_back(out_item_t'{char_out: NUL_CHAR, char_valid: 1'b0, last: 1'b0});
      tail = step_out.pop_back();
      tail.last = 1'b1;
      step_out.push_back(tail);
      buf_count = 0;
      streaming = 1'b0;
      word_emitted = 1'b0;
    end
    foreach (step_out[k]) expected_chars.push_back(step_out[k]);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued bytes, idling at random. A byte flagged to drain
  // first is held back until every predicted byte has come out.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    queued_byte_t nxt;
    if (rst) begin
      text_valid <= 1'b0;
    end else begin
      if (text_valid && !text_stall) begin
        rewrite_byte(text_item);
        bytes_taken++;
      end
      // A stalled transaction keeps its valid and payload untouched.
      if (!text_valid || !text_stall) begin
        if (source_bytes.size() != 0 && (quiet || $urandom_range(0, 99) >= 15) &&
            !(source_bytes[0].drain_first && expected_chars.size() != 0)) begin
          nxt = source_bytes.pop_front();
          text_item <= nxt.item;
          text_valid <= 1'b1;
        end else begin
          text_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transaction and drives the output stall.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: expected no result, got char_out=%02h char_valid=%0b last=%0b",
                   $time, result_item.char_out, result_item.char_valid, result_item.last);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          if (result_item.char_out !== want.char_out) begin
            $display("%0t: char_out expected %02h, got %02h",
                     $time, want.char_out, result_item.char_out);
            error_count++;
          end
          if (result_item.char_valid !== want.char_valid) begin
            $display("%0t: char_valid expected %0b, got %0b",
                     $time, want.char_valid, result_item.char_valid);
            error_count++;
          end
          if (result_item.last !== want.last) begin
            $display("%0t: last expected %0b, got %0b",
                     $time, want.last, result_item.last);
            error_count++;
          end
        end
      end
      // One long hold-off while the driver still has bytes to offer, so the
      // block fills up and has to stall its input.
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (hold_request && !hold_done && source_bytes.size() != 0) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !quiet && ($urandom_range(0, 99) < 15);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: gives up when no transaction of any kind moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (blank(c));
    return c;
  endfunction

  function automatic logic [7:0] gap_byte();
    int unsigned pick;
    pick = $urandom_range(0, 5);
    return (pick == 5) ? SPACE_CHAR : 8'(9 + pick);
  endfunction

  // Sixteen non-space bytes, so that any prefix can serve as a pattern.
  function automatic logic [127:0] word_bytes128();
    logic [127:0] w;
    for (int i = 0; i < 16; i++) w[i*8 +: 8] = word_byte();
    return w;
  endfunction

  function automatic void add_byte(input logic [7:0] c, input bit fin);
    queued_byte_t e;
    e.item.char_in = c;
    e.item.text_end = fin;
    e.drain_first = drain_next;
    drain_next = 1'b0;
    source_bytes.push_back(e);
    bytes_queued++;
  endfunction

  function automatic void add_gap();
    int unsigned n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) add_byte(gap_byte(), 1'b0);
  endfunction

  // Mostly words built around the pattern (exact, one byte off, cut short,
  // overlong), the rest plain random words and raw noise.
  function automatic void add_word();
    int unsigned plen;
    int unsigned kind;
    int unsigned len;
    int unsigned flip;
    logic [7:0]  c;
    plen = clamp16(pat_len_q);
    kind = $urandom_range(0, 11);
    if (plen == 0 && kind <= 6) kind = 8;
    case (kind)
      0, 1, 2, 3: begin
        for (int i = 0; i < plen; i++) add_byte(byte_at({pat_hi_q, pat_lo_q}, i), 1'b0);
      end
      4: begin
        flip = $urandom_range(0, plen - 1);
        for (int i = 0; i < plen; i++) begin
          c = byte_at({pat_hi_q, pat_lo_q}, i);
          if (i == flip) begin
            c = c ^ 8'(1 << $urandom_range(0, 7));
            if (blank(c)) c = c ^ 8'h80;
          end
          add_byte(c, 1'b0);
        end
      end
      5: begin
        len = $urandom_range(1, plen) - 1;
        for (int i = 0; i < len; i++) add_byte(byte_at({pat_hi_q, pat_lo_q}, i), 1'b0);
      end
      6: begin
        for (int i = 0; i < plen; i++) add_byte(byte_at({pat_hi_q, pat_lo_q}, i), 1'b0);
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) add_byte(word_byte(), 1'b0);
      end
      7, 8, 9: begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) add_byte(word_byte(), 1'b0);
      end
      default: begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
  endfunction

  // One text: words separated by whitespace runs, sometimes with leading or
  // trailing whitespace, closed by a byte that carries text_end. No further
  // words are started once the text has used up its byte budget.
  function automatic void add_text(input int unsigned words, input int unsigned budget);
    int unsigned  start;
    queued_byte_t e;
    start = bytes_queued;
    if ($urandom_range(0, 3) == 0) add_gap();
    for (int w = 0; w < words && bytes_queued - start < budget; w++) begin
      add_word();
      if (w + 1 < words || $urandom_range(0, 3) == 0) add_gap();
    end
    if (bytes_queued == start) begin
      add_byte(gap_byte(), 1'b1);
    end else begin
      e = source_bytes.pop_back();
      e.item.text_end = 1'b1;
      source_bytes.push_back(e);
    end
  endfunction

  task automatic random_texts(input int unsigned n);
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < n)
      add_text($urandom_range(1, 6), n - (bytes_queued - start));
  endtask

  // Waits until every queued byte went in and every predicted byte came out,
  // then lets the block settle for bytes that were held without a result.
  task automatic wait_idle();
    do @(negedge clk); while (bytes_taken != bytes_queued || expected_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_PATTERN_LOW:        pat_lo_q = val;
      REG_PATTERN_HIGH:       pat_hi_q = val;
      REG_PATTERN_LENGTH:     pat_len_q = val[4:0];
      REG_REPLACEMENT_LOW:    rep_lo_q = val;
      REG_REPLACEMENT_HIGH:   rep_hi_q = val;
      REG_REPLACEMENT_LENGTH: rep_len_q = val[4:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Writes all six registers. The length registers only keep their low five
  // bits, so the upper bits carry random junk.
  task automatic load_setting(input logic [127:0] pat, input logic [4:0] plen,
                              input logic [127:0] rep, input logic [4:0] rlen);
    write_reg(REG_PATTERN_LOW, pat[63:0]);
    write_reg(REG_PATTERN_HIGH, pat[127:64]);
    write_reg(REG_PATTERN_LENGTH, {$urandom, 27'($urandom), plen});
    write_reg(REG_REPLACEMENT_LOW, rep[63:0]);
    write_reg(REG_REPLACEMENT_HIGH, rep[127:64]);
    write_reg(REG_REPLACEMENT_LENGTH, {$urandom, 27'($urandom), rlen});
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: the pattern length is zero, so every word streams
    // straight through. Covers the zero byte, 0xFF, whitespace runs, a
    // whitespace-only text (bare end marker) and a one-byte text.
    add_byte(NUL_CHAR, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(SPACE_CHAR, 1'b0);
    add_byte(8'h0D, 1'b0);
    add_byte(8'h41, 1'b1);
    add_byte(SPACE_CHAR, 1'b1);
    add_byte(8'h7A, 1'b1);
    wait_idle();

    // Three-byte pattern, two-byte replacement. A write to an unused index
    // must leave everything alone.
    load_setting(word_bytes128(), 5'd3, word_bytes128(), 5'd2);
    write_reg(REG_SPARE, {$urandom, $urandom});
    // Exact match, a prefix, an overlong word, and a match that ends the text
    // on its own last byte.
    for (int i = 0; i < 3; i++) add_byte(byte_at({pat_hi_q, pat_lo_q}, i), 1'b0);
    add_byte(8'h09, 1'b0);
    for (int i = 0; i < 2; i++) add_byte(byte_at({pat_hi_q, pat_lo_q}, i), 1'b0);
    add_byte(8'h0B, 1'b0);
    for (int i = 0; i < 3; i++) add_byte(byte_at({pat_hi_q, pat_lo_q}, i), 1'b0);
    add_byte(NUL_CHAR, 1'b0);
    add_byte(SPACE_CHAR, 1'b0);
    for (int i = 0; i < 3; i++) add_byte(byte_at({pat_hi_q, pat_lo_q}, i), i == 2);
    // Random texts, with one pause halfway until the output has caught up.
    random_texts(28);
    drain_next = 1'b1;
    random_texts(28);
    wait_idle();

    // Extremes: all-ones pattern with an oversized length (saturates to 16),
    // all-zero replacement with an oversized length. The receiver takes its
    // long hold-off here while the driver keeps offering bytes.
    load_setting({128{1'b1}}, 5'd31, '0, 5'd31);
    random_texts(56);
    hold_request = 1'b1;
    wait_idle();

    // One-byte pattern replaced by an empty word, with no idling on either side.
    quiet = 1'b1;
    load_setting(word_bytes128(), 5'd1, word_bytes128(), 5'd0);
    random_texts(56);
    wait_idle();
    quiet = 1'b0;

    // Pattern length just past the buffer depth, full sixteen-byte replacement
    // of arbitrary bytes.
    load_setting(word_bytes128(), 5'd17, {$urandom, $urandom, $urandom, $urandom}, 5'd16);
    random_texts(56);
    wait_idle();

    // Zero pattern length written explicitly: nothing matches.
    load_setting('0, 5'd0, {128{1'b1}}, 5'd1);
    random_texts(56);
    wait_idle();

    // Random lengths, with a second drain pause in the middle.
    load_setting(word_bytes128(), 5'($urandom_range(1, 16)),
                 word_bytes128(), 5'($urandom_range(0, 16)));
    random_texts(28);
    drain_next = 1'b1;
    random_texts(28);
    wait_idle();

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
